### rtl/core/word_lz_decompressor_macros.svh
// Assertion helpers for the decompressor core.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef WORD_LZ_DECOMPRESSOR_MACROS_SVH
`define WORD_LZ_DECOMPRESSOR_MACROS_SVH

// A property that must hold at every clock edge.
`define WLZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define WLZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wlz_pkg.sv
package wlz_pkg;

    // Field and position widths.
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int POS_W    = 17;
    localparam int SRC_W    = 18;
    localparam int OFS_LSB  = 3;
    localparam int OFS_W    = 13;
    localparam int LEN_W    = 3;
    localparam int PAIRS_W  = 4;
    localparam int CNT_W    = 2;

    // Default size of the history memory in bytes.
    localparam int DEF_OUT_BYTES = 65536;

    // Token codes and window stepping.
    localparam logic [WORD_W-1:0]  MARKER_WORD = 16'hFFFF;
    localparam logic [POS_W-1:0]   WINDOW_STEP = 17'h02000;
    localparam logic [PAIRS_W-1:0] MIN_PAIRS   = 4'd2;

    // Byte counts carried with each output item.
    localparam logic [CNT_W-1:0] BYTE_ONE = 2'd1;
    localparam logic [CNT_W-1:0] BYTE_TWO = 2'd2;

endpackage

### rtl/core/wlz_hist_ram.sv
module wlz_hist_ram
    import wlz_pkg::*;
#(
    parameter int DEPTH = DEF_OUT_BYTES,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // One byte write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One byte read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/word_lz_decompressor.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  is_copy, token_word
// output    out        out_valid/out_stall  out_word, byte_count, last_of_run, finished
// config    in         cfg_wr_en            cfg_wr_data (total_bytes)
//
// A literal token goes from idle through the write states to the output state;
// a window marker or an ignored token is handled in idle alone. A copy token steps
// through two reads, one capture, two writes and one output state per byte pair, as
// the history memory ports are byte-wide. An output stall holds the output state.
// The block takes one token at a time and holds in_stall high until its last item leaves.
// Reset clears the size, write position and window base; the history memory is not
// cleared and needs no clearing pass, since only bytes written since the last restart
// are ever used.
`include "word_lz_decompressor_macros.svh"

module word_lz_decompressor
    import wlz_pkg::*;
#(
    parameter int OUT_BYTES = DEF_OUT_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [POS_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              is_copy,
    input  logic [WORD_W-1:0] token_word,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] out_word,
    output logic [CNT_W-1:0]  byte_count,
    output logic              last_of_run,
    output logic              finished
);

    localparam int AW    = $clog2(OUT_BYTES);
    localparam int CMP_W = ($clog2(OUT_BYTES + 1) > SRC_W) ? $clog2(OUT_BYTES + 1) : SRC_W;
    localparam logic [CMP_W-1:0] OUT_LIM = CMP_W'(OUT_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_CAP,
        ST_WR_LO,
        ST_WR_HI,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    total_reg, total_next;
    logic [POS_W-1:0]    wp_reg, wp_next;
    logic [POS_W-1:0]    win_reg, win_next;
    logic [SRC_W-1:0]    src_reg, src_next;
    logic [PAIRS_W-1:0]  pairs_reg, pairs_next;
    logic [WORD_W-1:0]   pair_reg, pair_next;
    logic                two_reg, two_next;
    logic                rd_ok_reg, rd_ok_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_word_reg, out_word_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                last_reg, last_next;
    logic                fin_reg, fin_next;

    logic [CMP_W-1:0]    total_ext;
    logic [POS_W-1:0]    lim;
    logic [POS_W-1:0]    wp_new;
    logic [SRC_W-1:0]    src_hi;
    logic [BYTE_W-1:0]   rd_byte;

    logic                ram_we;
    logic [AW-1:0]       ram_wa;
    logic [BYTE_W-1:0]   ram_wd;
    logic                ram_re;
    logic [AW-1:0]       ram_ra;
    logic [BYTE_W-1:0]   ram_rd;

    // A byte reads as stored only below the write position and inside the memory.
    function automatic logic rd_ok_f(input logic [SRC_W-1:0] a, input logic [POS_W-1:0] wp);
        logic below_wp;
        logic in_mem;
        below_wp = a < {1'b0, wp};
        in_mem   = CMP_W'(a) < OUT_LIM;
        return below_wp && in_mem;
    endfunction

    // The size limit is the configured size capped at the memory size.
    assign total_ext = CMP_W'(total_reg);
    assign lim       = (total_ext > OUT_LIM) ? POS_W'(OUT_LIM) : total_reg;

    assign src_hi  = src_reg + SRC_W'(1);
    assign rd_byte = rd_ok_reg ? ram_rd : '0;
    assign wp_new  = wp_reg + (two_reg ? POS_W'(2) : POS_W'(1));

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        wp_next        = wp_reg;
        win_next       = win_reg;
        src_next       = src_reg;
        pairs_next     = pairs_reg;
        pair_next      = pair_reg;
        two_next       = two_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        fin_next       = fin_reg;
        ram_we         = 1'b0;
        ram_wa         = AW'(wp_reg);
        ram_wd         = pair_reg[BYTE_W-1:0];
        ram_re         = 1'b0;
        ram_ra         = AW'(src_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    total_next = cfg_wr_data;
                    wp_next    = '0;
                    win_next   = '0;
                end
                else if (in_valid && (wp_reg < lim))
                begin
                    if (!is_copy)
                    begin
                        pair_next  = token_word;
                        pairs_next = PAIRS_W'(1);
                        state_next = ST_WR_LO;
                    end
                    else if (token_word == MARKER_WORD)
                    begin
                        win_next = win_reg + WINDOW_STEP;
                    end
                    else
                    begin
                        src_next   = {1'b0, win_reg}
                                   + SRC_W'(token_word[OFS_LSB +: OFS_W]);
                        pairs_next = PAIRS_W'(token_word[LEN_W-1:0]) + MIN_PAIRS;
                        state_next = ST_RD_LO;
                    end
                end
            end
            ST_RD_LO:
            begin
                ram_re     = 1'b1;
                ram_ra     = AW'(src_reg);
                rd_ok_next = rd_ok_f(src_reg, wp_reg);
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                pair_next[BYTE_W-1:0] = rd_byte;
                ram_re     = 1'b1;
                ram_ra     = AW'(src_hi);
                rd_ok_next = rd_ok_f(src_hi, wp_reg);
                state_next = ST_RD_CAP;
            end
            ST_RD_CAP:
            begin
                pair_next[WORD_W-1:BYTE_W] = rd_byte;
                state_next = ST_WR_LO;
            end
            ST_WR_LO:
            begin
                ram_we     = 1'b1;
                ram_wa     = AW'(wp_reg);
                ram_wd     = pair_reg[BYTE_W-1:0];
                two_next   = (lim - wp_reg) != POS_W'(1);
                state_next = ST_WR_HI;
            end
            ST_WR_HI:
            begin
                ram_we = two_reg;
                ram_wa = AW'(wp_reg + POS_W'(1));
                ram_wd = pair_reg[WORD_W-1:BYTE_W];
                out_word_next  = two_reg ? pair_reg : {{BYTE_W{1'b0}}, pair_reg[BYTE_W-1:0]};
                cnt_next       = two_reg ? BYTE_TWO : BYTE_ONE;
                fin_next       = wp_new >= lim;
                last_next      = (wp_new >= lim) || (pairs_reg == PAIRS_W'(1));
                out_valid_next = 1'b1;
                wp_next        = wp_new;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        src_next   = src_reg + SRC_W'(2);
                        pairs_next = pairs_reg - PAIRS_W'(1);
                        state_next = ST_RD_LO;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            wp_reg        <= '0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            wp_reg        <= wp_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        pairs_reg    <= pairs_next;
        pair_reg     <= pair_next;
        two_reg      <= two_next;
        rd_ok_reg    <= rd_ok_next;
        out_word_reg <= out_word_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        fin_reg      <= fin_next;
    end

    // History memory.
    wlz_hist_ram #(
        .DEPTH (OUT_BYTES),
        .AW    (AW)
    ) u_hist (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_word    = out_word_reg;
    assign byte_count  = cnt_reg;
    assign last_of_run = last_reg;
    assign finished    = fin_reg;

    // An odd final byte always ends the output and carries a clear high byte.
    `WLZ_ASSERT(a_odd_is_final,
        out_valid && (byte_count == BYTE_ONE)
            |-> finished && last_of_run && (out_word[WORD_W-1:BYTE_W] == '0),
        "odd byte item is not final")
    // Reaching the size limit always ends the token.
    `WLZ_ASSERT(a_fin_is_last, out_valid && finished |-> last_of_run, "finished item not marked last")
    // The write position never runs past the size limit.
    `WLZ_ASSERT(a_wp_in_limit, wp_reg <= lim, "write position beyond size limit")
    // A new token is only taken when no item is waiting.
    `WLZ_ASSERT(a_idle_no_out, !in_stall |-> !out_valid, "token taken while item pending")
    // After the last item of a token leaves, the block is idle again.
    `WLZ_ASSERT_NEXT(a_last_to_idle, out_valid && !out_stall && last_of_run,
        !out_valid && !in_stall, "block not idle after last item")

endmodule

### tb/tb_word_lz_decompressor.sv
module tb_word_lz_decompressor;
    import wlz_pkg::*;

    localparam int TOTAL_ITEMS   = 170;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTS    = 40;
    localparam int HIST_AW       = $clog2(DEF_OUT_BYTES);

    // One output item: two bytes, their count and the two flags.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  cnt;
        logic              last;
        logic              fin;
    } out_item_t;

    // Rows of the directed table: a size write or a token.
    typedef enum logic {ROW_SIZE, ROW_TOKEN} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [POS_W-1:0]  value;
        logic              copy;
        logic [WORD_W-1:0] word;
        logic              typed;
        logic              has_res;
        out_item_t         res;
    } token_row_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [POS_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic              is_copy;
    logic [WORD_W-1:0] token_word;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] out_word;
    logic [CNT_W-1:0]  byte_count;
    logic              last_of_run;
    logic              finished;

    // Shadow copy of the decompressor state.
    logic [BYTE_W-1:0] history_mem [DEF_OUT_BYTES];
    logic [POS_W-1:0]  size_cfg;
    logic [POS_W-1:0]  wr_pos;
    logic [POS_W-1:0]  win_base;

    out_item_t  pending_outputs [$];
    token_row_t directed_rows [$];

    int  error_count     = 0;
    int  tokens_sent     = 0;
    int  live_tokens     = 0;
    int  results_checked = 0;
    int  sizes_written   = 0;
    int  holds_done      = 0;
    int  burst_left      = 0;
    bit  gaps_on         = 1'b1;
    bit  hold_req        = 1'b0;

    always #1 clk = ~clk;

    word_lz_decompressor uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .is_copy     (is_copy),
        .token_word  (token_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word),
        .byte_count  (byte_count),
        .last_of_run (last_of_run),
        .finished    (finished)
    );

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("output %0d: %s is 0x%0h, wanted 0x%0h",
                                      results_checked, name, got, want));
    endtask

    // The output limit is the configured size, capped at the history size.
    function automatic int unsigned size_limit();
        return (size_cfg > DEF_OUT_BYTES) ? DEF_OUT_BYTES : 32'(size_cfg);
    endfunction

    // Bytes at or past the write position read as zero.
    function automatic logic [BYTE_W-1:0] history_byte(input int unsigned addr);
        if (addr >= wr_pos || addr >= DEF_OUT_BYTES)
            return '0;
        return history_mem[HIST_AW'(addr)];
    endfunction

    // Write one pair, or one byte when only one fits, and queue its output item.
    function automatic void store_pair(input logic [WORD_W-1:0] data);
        int unsigned      lim;
        logic [CNT_W-1:0] cnt;
        out_item_t        item;
        lim = size_limit();
        cnt = (lim - wr_pos < 2) ? BYTE_ONE : BYTE_TWO;
        if (wr_pos < DEF_OUT_BYTES)
            history_mem[HIST_AW'(wr_pos)] = data[BYTE_W-1:0];
        if (cnt == BYTE_TWO && wr_pos + 1 < DEF_OUT_BYTES)
            history_mem[HIST_AW'(wr_pos + 1)] = data[WORD_W-1:BYTE_W];
        if (cnt == BYTE_ONE)
            data[WORD_W-1:BYTE_W] = '0;
        wr_pos = wr_pos + cnt;
        item.word = data;
        item.cnt  = cnt;
        item.last = 1'b0;
        item.fin  = (wr_pos >= lim);
        pending_outputs.push_back(item);
    endfunction

    // Advance the shadow state by one token; returns the number of items queued.
    function automatic int decompress_token(input logic copy, input logic [WORD_W-1:0] word);
        int unsigned       lim;
        int unsigned       src;
        int unsigned       pairs;
        int                n;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        out_item_t         tail;
        lim = size_limit();
        n = 0;
        if (wr_pos >= lim)
            return 0;
        if (!copy)
        begin
            store_pair(word);
            n = 1;
        end
        else if (word == MARKER_WORD)
        begin
            win_base = win_base + WINDOW_STEP;
            return 0;
        end
        else
        begin
            src   = 32'(win_base) + 32'(word[OFS_LSB +: OFS_W]);
            pairs = 32'(word[LEN_W-1:0]) + 32'(MIN_PAIRS);
            while (pairs > 0 && wr_pos < lim)
            begin
                lo = history_byte(src);
                hi = history_byte(src + 1);
                store_pair({hi, lo});
                n++;
                src += 2;
                pairs--;
            end
        end
        if (n > 0)
        begin
            tail = pending_outputs.pop_back();
            tail.last = 1'b1;
            pending_outputs.push_back(tail);
        end
        return n;
    endfunction

    // Random token: mostly literals and copies that reach back into written data.
    function automatic void pick_token(output logic copy, output logic [WORD_W-1:0] word);
        int                r;
        int unsigned       span;
        logic [OFS_W-1:0]  ofs;
        logic [LEN_W-1:0]  len;
        r = $urandom_range(0, 99);
        ofs = OFS_W'($urandom);
        len = LEN_W'($urandom);
        copy = 1'b1;
        if (r < 45)
        begin
            copy = 1'b0;
            word = WORD_W'($urandom);
        end
        else if (r < 88)
        begin
            if (wr_pos > win_base)
            begin
                span = wr_pos - win_base;
                if (span > 8191)
                    span = 8191;
                if (r % 2)
                    ofs = OFS_W'($urandom_range(0, span));
                else
                    ofs = OFS_W'(span - $urandom_range(0, (span < 24) ? span : 24));
            end
            word = {ofs, len};
            if (word == MARKER_WORD)
                word[0] = 1'b0;
        end
        else if (r < 93)
            word = MARKER_WORD;
        else
            word = WORD_W'($urandom);
    endfunction

    function automatic void add_size(input logic [POS_W-1:0] value);
        token_row_t row;
        row = '0;
        row.kind  = ROW_SIZE;
        row.value = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_token(input logic copy, input logic [WORD_W-1:0] word);
        token_row_t row;
        row = '0;
        row.kind = ROW_TOKEN;
        row.copy = copy;
        row.word = word;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic copy, input logic [WORD_W-1:0] word,
                                      input logic has_res, input logic [WORD_W-1:0] rw,
                                      input logic [CNT_W-1:0] rc, input logic rl,
                                      input logic rf);
        token_row_t row;
        row = '0;
        row.kind     = ROW_TOKEN;
        row.copy     = copy;
        row.word     = word;
        row.typed    = 1'b1;
        row.has_res  = has_res;
        row.res.word = rw;
        row.res.cnt  = rc;
        row.res.last = rl;
        row.res.fin  = rf;
        directed_rows.push_back(row);
    endfunction

    // Offer one token and wait until the block takes it.
    task automatic send_token(input logic copy, input logic [WORD_W-1:0] word,
                              input logic typed, input logic has_res,
                              input out_item_t typed_res, output bit live);
        int n;
        @(negedge clk);
        in_valid   <= 1'b1;
        is_copy    <= copy;
        token_word <= word;
        do @(posedge clk); while (in_stall);
        live = (wr_pos < size_limit());
        n = decompress_token(copy, word);
        if (typed)
        begin
            repeat (n) void'(pending_outputs.pop_back());
            if (has_res)
                pending_outputs.push_back(typed_res);
        end
        tokens_sent++;
        if (live)
            live_tokens++;
    endtask

    // Sender pacing: bursts of back-to-back items separated by random gaps.
    task automatic pace();
        int gap;
        if (burst_left > 0 || !gaps_on)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Stop offering and wait until every queued output item has arrived.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Size write; this also restarts the window and the write position.
    task automatic write_size(input logic [POS_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        size_cfg = value;
        wr_pos   = '0;
        win_base = '0;
        sizes_written++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return POS_W'(DEF_OUT_BYTES);
            2:       return POS_W'($urandom_range(1, 15));
            3:       return POS_W'($urandom_range(1024, 65535));
            default: return POS_W'($urandom_range(16, 600));
        endcase
    endfunction

    // Output checker: every accepted item against the oldest expectation.
    always @(posedge clk)
    begin : watch_outputs
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output item, word 0x%0h", out_word));
            end
            else
            begin
                want = pending_outputs.pop_front();
                check_field("out_word", 32'(out_word), 32'(want.word));
                check_field("byte_count", 32'(byte_count), 32'(want.cnt));
                check_field("last_of_run", 32'(last_of_run), 32'(want.last));
                check_field("finished", 32'(finished), 32'(want.fin));
            end
            results_checked++;
        end
    end

    // Receiver: its own stall patterns, plus a long hold-off on request.
    initial
    begin : receiver
        stall_mode_t mode;
        int          left;
        int unsigned tick;
        out_stall = 1'b0;
        mode = STALL_NONE;
        left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 120);
                end
                left--;
                tick++;
                case (mode)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_PERIODIC: out_stall <= (tick % 5 < 2);
                    default:        out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    // Main stimulus: directed table, then random phases of size and tokens.
    initial
    begin : stimulus
        token_row_t  row;
        out_item_t   none;
        logic        copy;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  size;
        bit          live;
        int          random_live;
        int          phase;
        int          n_items;
        int          tail;
        int          i;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        is_copy     = 1'b0;
        token_word  = '0;
        size_cfg    = '0;
        wr_pos      = '0;
        win_base    = '0;
        none        = '0;
        random_live = 0;
        phase       = 0;

        // Size zero after reset: everything is ignored, window markers too.
        add_typed(1'b0, 16'h1234, 1'b0, 16'h0000, BYTE_TWO, 1'b0, 1'b0);
        add_typed(1'b1, 16'h0000, 1'b0, 16'h0000, BYTE_TWO, 1'b0, 1'b0);
        add_typed(1'b1, MARKER_WORD, 1'b0, 16'h0000, BYTE_TWO, 1'b0, 1'b0);
        // Odd size: a copy is cut short on a single final byte, then nothing more.
        add_size(17'd7);
        add_typed(1'b0, 16'h0000, 1'b1, 16'h0000, BYTE_TWO, 1'b1, 1'b0);
        add_typed(1'b0, 16'hFFFF, 1'b1, 16'hFFFF, BYTE_TWO, 1'b1, 1'b0);
        add_token(1'b1, 16'h0000);
        add_typed(1'b0, 16'h5A5A, 1'b0, 16'h0000, BYTE_TWO, 1'b0, 1'b0);
        add_typed(1'b1, MARKER_WORD, 1'b0, 16'h0000, BYTE_TWO, 1'b0, 1'b0);
        // Largest size: overlapping copies, reads past the write position, window step.
        add_size(POS_W'(DEF_OUT_BYTES));
        add_typed(1'b0, 16'hA55A, 1'b1, 16'hA55A, BYTE_TWO, 1'b1, 1'b0);
        add_typed(1'b0, 16'h3CC3, 1'b1, 16'h3CC3, BYTE_TWO, 1'b1, 1'b0);
        add_token(1'b1, 16'h0007);
        add_token(1'b1, 16'h0008);
        add_token(1'b1, 16'hFFFE);
        add_typed(1'b1, MARKER_WORD, 1'b0, 16'h0000, BYTE_TWO, 1'b0, 1'b0);
        add_token(1'b1, 16'h0001);
        add_typed(1'b0, 16'hFFFF, 1'b1, 16'hFFFF, BYTE_TWO, 1'b1, 1'b0);
        // Size of one: a literal yields a single byte and finishes the stream.
        add_size(17'd1);
        add_typed(1'b0, 16'hABCD, 1'b1, 16'h00CD, BYTE_ONE, 1'b1, 1'b1);
        add_typed(1'b0, 16'h1111, 1'b0, 16'h0000, BYTE_TWO, 1'b0, 1'b0);
        // Size five: a three-pair copy stops after its odd byte.
        add_size(17'd5);
        add_typed(1'b0, 16'h0102, 1'b1, 16'h0102, BYTE_TWO, 1'b1, 1'b0);
        add_token(1'b1, 16'h0001);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_SIZE)
            begin
                write_size(row.value);
            end
            else
            begin
                send_token(row.copy, row.word, row.typed, row.has_res, row.res, live);
                pace();
            end
        end

        // Random phases, each behind a fresh size setting.
        while (tokens_sent < TOTAL_ITEMS)
        begin
            if (phase == 1)
                size = POS_W'($urandom_range(2048, 8192));
            else if (phase == 2)
                size = POS_W'(DEF_OUT_BYTES);
            else
                size = pick_size();
            write_size(size);
            gaps_on = (phase % 3 != 1);
            if (phase == 1)
                hold_req = 1'b1;
            // Sixteen window steps wrap the window base back to zero.
            if (phase == 2)
            begin
                repeat (16)
                begin
                    send_token(1'b1, MARKER_WORD, 1'b0, 1'b0, none, live);
                    if (live)
                        random_live++;
                end
            end
            n_items = $urandom_range(12, 40);
            tail = 0;
            for (i = 0; i < n_items; i++)
            begin
                if (tokens_sent >= TOTAL_ITEMS)
                    break;
                if (phase == 3 && i == n_items / 2)
                    wait_drained();
                pick_token(copy, word);
                send_token(copy, word, 1'b0, 1'b0, none, live);
                if (live)
                    random_live++;
                pace();
                if (wr_pos >= size_limit())
                begin
                    tail++;
                    if (tail > 2)
                        break;
                end
            end
            phase++;
        end

        wait_drained();
        if (pending_outputs.size() != 0)
            report_mismatch($sformatf("%0d output items never arrived", pending_outputs.size()));

        $display("Sent %0d tokens (%0d while output was open, %0d random) over %0d sizes.",
                 tokens_sent, live_tokens, random_live, sizes_written);
        $display("Checked %0d output items; %0d long receiver hold-offs, one window wrap.",
                 results_checked, holds_done);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #2000000;
        $display("Timeout: %0d output items still outstanding.", pending_outputs.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/wlz_pkg.sv
rtl/core/wlz_hist_ram.sv
rtl/core/word_lz_decompressor.sv
tb/tb_word_lz_decompressor.sv
